>>> src/msg_pkg.sv
// shared types and constants of the multi-axis step generator
// used by msg_front, msg_mac, msg_back and the top level; depends on nothing
package msg_pkg;

   // default sizes
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int AXIS_COUNT_DEF  = 8;

   // function codes on the input channel
   localparam logic [2:0] FUNC_TICK   = 3'd0;
   localparam logic [2:0] FUNC_HEADER = 3'd1;
   localparam logic [2:0] FUNC_TARGET = 3'd2;
   localparam logic [2:0] FUNC_COMMIT = 3'd3;
   localparam logic [2:0] FUNC_STOP   = 3'd4;

   // position fraction cap (p = 2 in units of 2^-49) and rounding half
   localparam logic [112:0] P_CAP      = 113'h1 << 50;
   localparam logic [82:0]  ROUND_HALF = 83'h1 << 48;

   typedef enum logic [2:0] {
      OP_TICK, OP_HEADER, OP_TARGET, OP_COMMIT, OP_STOP, OP_BAD
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   // classified command handed from front to back
   typedef struct packed {
      op_type      op;
      logic [7:0]  pin_mask;
      logic [31:0] duration;
      logic [31:0] speed;
      logic [47:0] accel;
      logic [2:0]  axis;
      logic [31:0] target;
   } cmd_type;

   // one result transaction
   typedef struct packed {
      logic [7:0]  step_mask;
      logic [7:0]  direction_mask;
      logic [7:0]  enable_n;
      logic        move_active;
      logic        move_finished;
      logic [31:0] missed_steps;
      logic [31:0] out_of_time;
      logic [4:0]  queue_level;
      status_type  status;
   } rsp_type;

   // multiply-accumulate job request and result
   typedef struct packed {
      logic        start;
      logic [79:0] a;
      logic [31:0] b;
      logic [1:0]  chunks;
   } mac_req_type;

   typedef struct packed {
      logic         done;
      logic [111:0] acc;
   } mac_rsp_type;

endpackage

>>> src/msg_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module msg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> src/msg_front.sv
// input side: accepts transactions, decodes the function code and queues
// classified commands in a two-entry queue; depends on msg_pkg
module msg_front #(
   parameter int AXIS_COUNT = msg_pkg::AXIS_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [159:0]     req_tdata,
   input  logic [2:0]       req_tuser,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output msg_pkg::cmd_type cmd
);
   import msg_pkg::*;

   cmd_type    slot_ff [2];
   cmd_type    slot_in [2];
   logic [1:0] level_ff, level_in;
   cmd_type    decoded;
   logic       push, pop;

   // classify the incoming transaction
   always_comb begin
      decoded.pin_mask = req_tdata[7:0];
      decoded.duration = req_tdata[39:8];
      decoded.speed    = req_tdata[71:40];
      decoded.accel    = req_tdata[119:72];
      decoded.axis     = req_tdata[122:120];
      decoded.target   = req_tdata[154:123];
      unique case (req_tuser)
         FUNC_TICK:   decoded.op = OP_TICK;
         FUNC_HEADER: decoded.op = OP_HEADER;
         FUNC_TARGET: begin
            if (int'(req_tdata[122:120]) < AXIS_COUNT) decoded.op = OP_TARGET;
            else decoded.op = OP_BAD;
         end
         FUNC_COMMIT: decoded.op = OP_COMMIT;
         FUNC_STOP:   decoded.op = OP_STOP;
         default:     decoded.op = OP_BAD;
      endcase
   end

   assign req_tready = (level_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (level_ff != 2'd0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = slot_ff[0];

   // two-entry queue, oldest in slot 0
   always_comb begin
      slot_in  = slot_ff;
      level_in = level_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (push) begin
         if (level_ff == 2'd0 || (level_ff == 2'd1 && pop)) slot_in[0] = decoded;
         else slot_in[1] = decoded;
      end
      level_in = level_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 2'd0;
      end else begin
         level_ff <= level_in;
      end
      slot_ff <= slot_in;
   end

endmodule

>>> src/msg_mac.sv
// shared 32x32 multiply-accumulate unit: multiplies an operand of up to
// three 32-bit chunks by a 32-bit value, one chunk a cycle; uses msg_pkg
module msg_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  msg_pkg::mac_req_type req,
   output msg_pkg::mac_rsp_type rsp
);
   import msg_pkg::*;

   logic         active_ff, active_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic [1:0]   chunks_ff, chunks_in;
   logic [95:0]  a_ff, a_in;
   logic [31:0]  b_ff, b_in;
   logic         pend_ff, pend_in;
   logic [1:0]   pidx_ff, pidx_in;
   logic [63:0]  prod_ff, prod_in;
   logic [111:0] acc_ff, acc_in;
   logic         done_ff, done_in;

   // issue one chunk product a cycle, add the registered one
   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      chunks_in = chunks_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      pend_in   = 1'b0;
      pidx_in   = cnt_ff;
      prod_in   = a_ff[32*cnt_ff +: 32] * b_ff;
      acc_in    = acc_ff;
      done_in   = pend_ff && (pidx_ff == chunks_ff - 2'd1);
      if (pend_ff) begin
         acc_in = acc_ff + (112'(prod_ff) << (32 * pidx_ff));
      end
      if (active_ff) begin
         pend_in = 1'b1;
         cnt_in  = cnt_ff + 2'd1;
         if (cnt_ff == chunks_ff - 2'd1) active_in = 1'b0;
      end
      if (req.start) begin
         active_in = 1'b1;
         cnt_in    = 2'd0;
         chunks_in = req.chunks;
         a_in      = 96'(req.a);
         b_in      = req.b;
         pend_in   = 1'b0;
         acc_in    = '0;
         done_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
         done_ff   <= done_in;
      end
      cnt_ff    <= cnt_in;
      chunks_ff <= chunks_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      pidx_ff   <= pidx_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
   end

   assign rsp.done = done_ff;
   assign rsp.acc  = acc_ff;

endmodule

>>> src/msg_back.sv
// execution side: staging, move queue, tick sequencer and result register
// uses msg_pkg, msg_ram and msg_mac
module msg_back #(
   parameter int QUEUE_DEPTH = msg_pkg::QUEUE_DEPTH_DEF,
   parameter int AXIS_COUNT  = msg_pkg::AXIS_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  msg_pkg::cmd_type cmd,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output msg_pkg::rsp_type rsp
);
   import msg_pkg::*;

   localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int TD  = QUEUE_DEPTH * AXIS_COUNT;
   localparam int TW  = (TD > 1) ? $clog2(TD) : 1;
   localparam int AXW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
   localparam int NW  = $clog2(AXIS_COUNT + 1);
   localparam int HDW = 112 + AXIS_COUNT;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b00000001,
      S_COMMIT = 8'b00000010,
      S_MULW   = 8'b00000100,
      S_SAT    = 8'b00001000,
      S_AXIS   = 8'b00010000,
      S_AXW    = 8'b00100000,
      S_AXEND  = 8'b01000000,
      S_LOAD   = 8'b10000000
   } state_type;

   typedef enum logic [1:0] {JOB_SPEED, JOB_ACCEL, JOB_SQUARE} job_type;

   state_type       state_ff, state_in;
   job_type         job_ff, job_in;
   logic [7:0]      enable_ff, enable_in;
   logic [7:0]      stg_pins_ff, stg_pins_in;
   logic [31:0]     stg_dur_ff, stg_dur_in;
   logic [31:0]     stg_spd_ff, stg_spd_in;
   logic [47:0]     stg_acc_ff, stg_acc_in;
   logic [31:0]     stg_tgt_ff [AXIS_COUNT];
   logic [31:0]     stg_tgt_in [AXIS_COUNT];
   logic [HW-1:0]   head_ff, head_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AXIS_COUNT-1:0] cur_pins_ff, cur_pins_in;
   logic [31:0]     cur_dur_ff, cur_dur_in;
   logic [31:0]     cur_spd_ff, cur_spd_in;
   logic [47:0]     cur_acc_ff, cur_acc_in;
   logic [31:0]     cur_tgt_ff [AXIS_COUNT];
   logic [31:0]     cur_tgt_in [AXIS_COUNT];
   logic [31:0]     steps_ff [AXIS_COUNT];
   logic [31:0]     steps_in [AXIS_COUNT];
   logic            move_valid_ff, move_valid_in;
   logic            pulse_ff, pulse_in;
   logic [31:0]     tick_ff, tick_in;
   logic [31:0]     start_ff, start_in;
   logic [AXIS_COUNT-1:0] held_dir_ff, held_dir_in;
   logic [31:0]     missed_ff, missed_in;
   logic [31:0]     overrun_ff, overrun_in;
   logic [31:0]     t_ff, t_in;
   logic [80:0]     vw_ff, vw_in;
   logic [112:0]    s_ff, s_in;
   logic [50:0]     smag_ff, smag_in;
   logic [AXW-1:0]  ax_ff, ax_in;
   logic [NW-1:0]   cnt_ff, cnt_in;
   logic            all_done_ff, all_done_in;
   logic [AXIS_COUNT-1:0] dir_ff, dir_in;
   logic [AXIS_COUNT-1:0] step_ff, step_in;
   logic            fin_ff, fin_in;
   status_type      status_ff, status_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;
   logic            respond;

   mac_req_type     mac_req;
   mac_rsp_type     mac_rsp;

   logic            start;
   logic [CW:0]     slot_sum;
   logic [HW-1:0]   slot;
   logic [CW-1:0]   head_next;
   logic            hdr_we, tgt_we;
   logic [HDW-1:0]  hdr_rd_data;
   logic [31:0]     tgt_rd_data;
   logic [TW-1:0]   tgt_wr_addr, tgt_rd_addr;
   logic [31:0]     cur_steps, cur_raw, tmag;
   logic            tneg, ax_active, ax_last, late, acc_neg;
   logic [47:0]     amag;
   logic [82:0]     round_sum;
   logic [33:0]     r_val;
   logic [112:0]    vw_wide, aw_wide;

   // queue slot arithmetic
   assign slot_sum  = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign slot      = (slot_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                      HW'(slot_sum - (CW+1)'(QUEUE_DEPTH)) : HW'(slot_sum);
   assign head_next = (CW'(head_ff) + CW'(1) == CW'(QUEUE_DEPTH)) ?
                      CW'(0) : CW'(head_ff) + CW'(1);
   assign tgt_wr_addr = TW'(TW'(slot) * TW'(AXIS_COUNT) + TW'(cnt_ff));
   assign tgt_rd_addr = TW'(TW'(head_ff) * TW'(AXIS_COUNT) + TW'(cnt_ff));
   assign hdr_we = (state_ff == S_COMMIT) && (cnt_ff == NW'(0));
   assign tgt_we = (state_ff == S_COMMIT);

   // move queue stores
   msg_ram #(.WIDTH(HDW), .DEPTH(QUEUE_DEPTH)) u_hdr_ram (
      .clock   (clock),
      .wr_en   (hdr_we),
      .wr_addr (slot),
      .wr_data ({stg_acc_ff, stg_spd_ff, stg_dur_ff, AXIS_COUNT'(stg_pins_ff)}),
      .rd_addr (head_ff),
      .rd_data (hdr_rd_data)
   );

   msg_ram #(.WIDTH(32), .DEPTH(TD)) u_tgt_ram (
      .clock   (clock),
      .wr_en   (tgt_we),
      .wr_addr (tgt_wr_addr),
      .wr_data (stg_tgt_ff[AXW'(cnt_ff)]),
      .rd_addr (tgt_rd_addr),
      .rd_data (tgt_rd_data)
   );

   msg_mac u_mac (
      .clock (clock),
      .reset (reset),
      .req   (mac_req),
      .rsp   (mac_rsp)
   );

   // per-axis and fraction helpers
   assign cur_steps = steps_ff[ax_ff];
   assign cur_raw   = cur_tgt_ff[ax_ff];
   assign tneg      = cur_raw[31];
   assign tmag      = tneg ? 32'(32'd0 - cur_raw) : cur_raw;
   assign ax_active = cur_pins_ff[ax_ff] && (cur_steps < tmag);
   assign ax_last   = (ax_ff == AXW'(AXIS_COUNT - 1));
   assign late      = t_ff > cur_dur_ff;
   assign acc_neg   = cur_acc_ff[47];
   assign amag      = acc_neg ? 48'(48'd0 - cur_acc_ff) : cur_acc_ff;
   assign round_sum = mac_rsp.acc[82:0] + ROUND_HALF;
   assign r_val     = round_sum[82:49];
   assign vw_wide   = 113'(vw_ff);
   assign aw_wide   = 113'(mac_rsp.acc);

   assign start     = (state_ff == S_IDLE) && cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = start;

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      enable_in     = enable_ff;
      stg_pins_in   = stg_pins_ff;
      stg_dur_in    = stg_dur_ff;
      stg_spd_in    = stg_spd_ff;
      stg_acc_in    = stg_acc_ff;
      stg_tgt_in    = stg_tgt_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      cur_pins_in   = cur_pins_ff;
      cur_dur_in    = cur_dur_ff;
      cur_spd_in    = cur_spd_ff;
      cur_acc_in    = cur_acc_ff;
      cur_tgt_in    = cur_tgt_ff;
      steps_in      = steps_ff;
      move_valid_in = move_valid_ff;
      pulse_in      = pulse_ff;
      tick_in       = tick_ff;
      start_in      = start_ff;
      held_dir_in   = held_dir_ff;
      missed_in     = missed_ff;
      overrun_in    = overrun_ff;
      t_in          = t_ff;
      vw_in         = vw_ff;
      s_in          = s_ff;
      smag_in       = smag_ff;
      ax_in         = ax_ff;
      cnt_in        = cnt_ff;
      all_done_in   = all_done_ff;
      dir_in        = dir_ff;
      step_in       = step_ff;
      fin_in        = fin_ff;
      status_in     = status_ff;
      respond       = 1'b0;
      mac_req       = '0;

      if (csr_wr_en) begin
         enable_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               step_in   = '0;
               fin_in    = 1'b0;
               status_in = ST_OK;
               case (cmd.op)
                  OP_HEADER: begin
                     stg_pins_in = cmd.pin_mask;
                     stg_dur_in  = cmd.duration;
                     stg_spd_in  = cmd.speed;
                     stg_acc_in  = cmd.accel;
                     respond     = 1'b1;
                  end
                  OP_TARGET: begin
                     stg_tgt_in[AXW'(cmd.axis)] = cmd.target;
                     respond = 1'b1;
                  end
                  OP_COMMIT: begin
                     if (count_ff >= CW'(QUEUE_DEPTH)) begin
                        status_in = ST_FULL;
                        respond   = 1'b1;
                     end else begin
                        cnt_in   = '0;
                        state_in = S_COMMIT;
                     end
                  end
                  OP_STOP: begin
                     move_valid_in = 1'b0;
                     pulse_in      = 1'b0;
                     count_in      = '0;
                     head_in       = '0;
                     enable_in     = '0;
                     respond       = 1'b1;
                  end
                  OP_TICK: begin
                     if (pulse_ff) begin
                        pulse_in = 1'b0;
                        tick_in  = tick_ff + 32'd1;
                        respond  = 1'b1;
                     end else if (move_valid_ff) begin
                        // first product: speed times elapsed ticks
                        t_in           = tick_ff - start_ff;
                        mac_req.start  = 1'b1;
                        mac_req.a      = 80'(cur_spd_ff);
                        mac_req.b      = tick_ff - start_ff;
                        mac_req.chunks = 2'd1;
                        job_in         = JOB_SPEED;
                        state_in       = S_MULW;
                     end else if (count_ff != CW'(0)) begin
                        cnt_in   = '0;
                        state_in = S_LOAD;
                     end else begin
                        tick_in = tick_ff + 32'd1;
                        respond = 1'b1;
                     end
                  end
                  default: begin
                     status_in = ST_BAD;
                     respond   = 1'b1;
                  end
               endcase
            end
         end

         // copy the staged move into the queue, one target a cycle
         S_COMMIT: begin
            cnt_in = cnt_ff + NW'(1);
            if (cnt_ff == NW'(AXIS_COUNT - 1)) begin
               count_in = count_ff + CW'(1);
               respond  = 1'b1;
               state_in = S_IDLE;
            end
         end

         // fraction products: speed*t, |accel|*t, then times t again
         S_MULW: begin
            if (mac_rsp.done) begin
               unique case (job_ff)
                  JOB_SPEED: begin
                     vw_in          = {mac_rsp.acc[63:0], 17'd0};
                     mac_req.start  = 1'b1;
                     mac_req.a      = 80'(amag);
                     mac_req.b      = t_ff;
                     mac_req.chunks = 2'd2;
                     job_in         = JOB_ACCEL;
                  end
                  JOB_ACCEL: begin
                     mac_req.start  = 1'b1;
                     mac_req.a      = mac_rsp.acc[79:0];
                     mac_req.b      = t_ff;
                     mac_req.chunks = 2'd3;
                     job_in         = JOB_SQUARE;
                  end
                  JOB_SQUARE: begin
                     if (!acc_neg) s_in = vw_wide + aw_wide;
                     else if (vw_wide >= aw_wide) s_in = vw_wide - aw_wide;
                     else s_in = aw_wide - vw_wide;
                     state_in = S_SAT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         // saturate the fraction magnitude and start the axis sweep
         S_SAT: begin
            smag_in     = (s_ff > P_CAP) ? P_CAP[50:0] : s_ff[50:0];
            ax_in       = '0;
            all_done_in = 1'b1;
            dir_in      = '0;
            state_in    = S_AXIS;
         end

         // unfinished axis: multiply fraction by target magnitude
         S_AXIS: begin
            if (ax_active) begin
               all_done_in    = 1'b0;
               mac_req.start  = 1'b1;
               mac_req.a      = 80'(smag_ff);
               mac_req.b      = tmag;
               mac_req.chunks = 2'd2;
               state_in       = S_AXW;
            end else if (ax_last) begin
               state_in = S_AXEND;
            end else begin
               ax_in = ax_ff + AXW'(1);
            end
         end

         // step, miss and overrun decisions for one axis
         S_AXW: begin
            if (mac_rsp.done) begin
               if (late && overrun_ff != '1) overrun_in = overrun_ff + 32'd1;
               if (r_val > 34'(cur_steps) + 34'd1 && missed_ff != '1) begin
                  missed_in = missed_ff + 32'd1;
               end
               if (late || r_val > 34'(cur_steps)) begin
                  steps_in[ax_ff] = cur_steps + 32'd1;
                  step_in[ax_ff]  = 1'b1;
                  if (!tneg && cur_raw != 32'd0) dir_in[ax_ff] = 1'b1;
               end
               if (ax_last) state_in = S_AXEND;
               else begin
                  ax_in    = ax_ff + AXW'(1);
                  state_in = S_AXIS;
               end
            end
         end

         // close the pulse phase, maybe pop the next move
         S_AXEND: begin
            held_dir_in = dir_ff;
            pulse_in    = 1'b1;
            if (all_done_ff) begin
               move_valid_in = 1'b0;
               fin_in        = 1'b1;
            end
            if (all_done_ff && count_ff != CW'(0)) begin
               cnt_in   = '0;
               state_in = S_LOAD;
            end else begin
               tick_in  = tick_ff + 32'd1;
               respond  = 1'b1;
               state_in = S_IDLE;
            end
         end

         // read the head move, header and one target a cycle
         S_LOAD: begin
            cnt_in = cnt_ff + NW'(1);
            if (cnt_ff != NW'(0)) begin
               cur_tgt_in[AXW'(cnt_ff - NW'(1))] = tgt_rd_data;
            end
            if (cnt_ff == NW'(1)) begin
               {cur_acc_in, cur_spd_in, cur_dur_in, cur_pins_in} = hdr_rd_data;
            end
            if (cnt_ff == NW'(AXIS_COUNT)) begin
               for (int i = 0; i < AXIS_COUNT; i++) steps_in[i] = '0;
               head_in       = HW'(head_next);
               count_in      = count_ff - CW'(1);
               move_valid_in = 1'b1;
               start_in      = tick_ff;
               tick_in       = tick_ff + 32'd1;
               respond       = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // result register, filled from the state after the transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (respond) begin
         rsp_valid_in          = 1'b1;
         rsp_in.step_mask      = 8'(step_in);
         rsp_in.direction_mask = 8'(held_dir_in);
         rsp_in.enable_n       = ~enable_in;
         rsp_in.move_active    = move_valid_in;
         rsp_in.move_finished  = fin_in;
         rsp_in.missed_steps   = missed_in;
         rsp_in.out_of_time    = overrun_in;
         rsp_in.queue_level    = 5'(count_in);
         rsp_in.status         = status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         enable_ff     <= '0;
         stg_pins_ff   <= '0;
         stg_dur_ff    <= '0;
         stg_spd_ff    <= '0;
         stg_acc_ff    <= '0;
         for (int i = 0; i < AXIS_COUNT; i++) begin
            stg_tgt_ff[i] <= '0;
            cur_tgt_ff[i] <= '0;
            steps_ff[i]   <= '0;
         end
         head_ff       <= '0;
         count_ff      <= '0;
         cur_pins_ff   <= '0;
         cur_dur_ff    <= '0;
         cur_spd_ff    <= '0;
         cur_acc_ff    <= '0;
         move_valid_ff <= 1'b0;
         pulse_ff      <= 1'b0;
         tick_ff       <= '0;
         start_ff      <= '0;
         held_dir_ff   <= '0;
         missed_ff     <= '0;
         overrun_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         enable_ff     <= enable_in;
         stg_pins_ff   <= stg_pins_in;
         stg_dur_ff    <= stg_dur_in;
         stg_spd_ff    <= stg_spd_in;
         stg_acc_ff    <= stg_acc_in;
         stg_tgt_ff    <= stg_tgt_in;
         cur_tgt_ff    <= cur_tgt_in;
         steps_ff      <= steps_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         cur_pins_ff   <= cur_pins_in;
         cur_dur_ff    <= cur_dur_in;
         cur_spd_ff    <= cur_spd_in;
         cur_acc_ff    <= cur_acc_in;
         move_valid_ff <= move_valid_in;
         pulse_ff      <= pulse_in;
         tick_ff       <= tick_in;
         start_ff      <= start_in;
         held_dir_ff   <= held_dir_in;
         missed_ff     <= missed_in;
         overrun_ff    <= overrun_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      job_ff      <= job_in;
      t_ff        <= t_in;
      vw_ff       <= vw_in;
      s_ff        <= s_in;
      smag_ff     <= smag_in;
      ax_ff       <= ax_in;
      cnt_ff      <= cnt_in;
      all_done_ff <= all_done_in;
      dir_ff      <= dir_in;
      step_ff     <= step_in;
      fin_ff      <= fin_in;
      status_ff   <= status_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> src/multi_axis_step_generator.sv
// top level of the multi-axis step generator
// depends on msg_pkg, msg_front and msg_back
//
// Usage: each req transaction carries one command, selected by req_tuser:
// tick, stage header, stage axis target, commit staged move, stop. Every
// command returns exactly one rsp transaction with the step lines of this
// tick, held direction lines, driver enables, move and queue status and
// the missed-step and overrun counters. csr_wr_en/csr_wr_data write the
// driver enable mask. A command waits in the front queue, runs in the
// back end, then is held in the result register. Header, target, stop,
// bad commands, clear-phase ticks and ticks with nothing to do are done
// in the idle state; a commit writes the header and one queue target a
// cycle; a pulse-phase tick runs the fraction products on the shared
// 32x32 multiplier, then a product per moving axis and a skip of every
// other axis, then closes; popping a move adds the queue reads of its
// header and targets. One command runs at a time. A two-entry command
// queue takes new transactions, while it has room, when the back end
// works or a result waits. While a result waits and rsp_tready is low,
// it is held and the back end starts nothing new. Reset empties both
// queues, clears the move state, the counters and the enable mask.
module multi_axis_step_generator #(
   parameter int QUEUE_DEPTH = msg_pkg::QUEUE_DEPTH_DEF,
   parameter int AXIS_COUNT  = msg_pkg::AXIS_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pin_mask, duration_ticks, initial_speed, acceleration, axis, target, pad
   input  logic [159:0] req_tdata,
   // func
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // step_mask, direction_mask, enable_n, move_active, move_finished,
   // missed_steps, out_of_time, queue_level, pad
   output logic [95:0]  rsp_tdata,
   // status
   output logic [1:0]   rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);
   import msg_pkg::*;

   logic    cmd_valid, cmd_ready;
   cmd_type cmd;
   rsp_type rsp;

   msg_front #(.AXIS_COUNT(AXIS_COUNT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   msg_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .AXIS_COUNT(AXIS_COUNT)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   // pack the result, first field in the lowest bits
   assign rsp_tdata = {1'b0, rsp.queue_level, rsp.out_of_time, rsp.missed_steps,
                       rsp.move_finished, rsp.move_active, rsp.enable_n,
                       rsp.direction_mask, rsp.step_mask};
   assign rsp_tuser = rsp.status;

endmodule
